// ===== design/ctpf_pkg.sv =====
`default_nettype none

package ctpf_pkg;

	// Item kinds on the input channel.
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_WIDTH,
		CFG_HEIGHT,
		CFG_SCAN,
		CFG_MASK,
		CFG_BSTR,
		CFG_BTHR,
		CFG_BNORM
	} cfg_index_t;

	// Fixed-point constants.
	localparam int LIGHT_W = 17;
	localparam int LOG_FRAC = 20;
	localparam logic [12:0] ONE_Q12 = 13'd4096;
	localparam logic [11:0] HALF_Q12 = 12'd2048;
	localparam logic [11:0] LUMA_R = 12'd1225;
	localparam logic [11:0] LUMA_G = 12'd2404;
	localparam logic [11:0] LUMA_B = 12'd467;
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
	localparam logic [16:0] LIGHT_MAX = 17'd65536;

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		logic [11:0] scan;
		logic [11:0] mask;
		logic [11:0] bstr;
		logic [11:0] bthr;
		logic [24:0] bnorm;
	} shade_cfg_t;

	typedef struct packed {
		logic start;
		logic left_ok;
		logic right_ok;
		logic above_ok;
		logic below_ok;
		logic odd_row;
		logic [1:0] phase;
	} shade_ctl_t;

	typedef struct packed {
		pixel_t center;
		pixel_t left;
		pixel_t right;
		pixel_t above;
		pixel_t below;
	} shade_pix_t;

	// Square-law table from an 8-bit code to Q1.16 linear light.
	function automatic logic [256*LIGHT_W-1:0] build_light();
		logic [256*LIGHT_W-1:0] lut;
		longint val;
		int c;
		lut = '0;
		for (c = 0; c < 256; c++) begin
			val = (longint'(c) * longint'(c) * 65536 + 32512) / 65025;
			lut[LIGHT_W*c +: LIGHT_W] = LIGHT_W'(val);
		end
		return lut;
	endfunction

	localparam logic [256*LIGHT_W-1:0] LIGHT_LUT = build_light();

	function automatic logic [LIGHT_W-1:0] light16(input logic [7:0] c);
		return LIGHT_LUT[LIGHT_W*int'(c) +: LIGHT_W];
	endfunction

	// Integer base-2 log with LOG_FRAC fraction bits, by repeated squaring.
	function automatic longint log2_fixed(input longint unsigned a);
		longint unsigned m;
		longint unsigned t;
		longint unsigned f;
		int n;
		int i;
		n = 0;
		t = a;
		f = 0;
		while (t > 1) begin
			t = t >> 1;
			n++;
		end
		m = a << (31 - n);
		for (i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			f = f << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				f = f | 64'd1;
			end
		end
		return longint'((longint'(n) << LOG_FRAC) | longint'(f));
	endfunction

endpackage

`default_nettype wire

// ===== design/ctpf_line_store.sv =====
`default_nettype none

module ctpf_line_store #(
	parameter int MAX_WIDTH = 1024
) (
	input wire logic clk,
	input wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input wire logic wr_en,
	input wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input wire ctpf_pkg::pixel_t wr_above,
	input wire ctpf_pkg::pixel_t wr_center,
	output ctpf_pkg::pixel_t rd_above,
	output ctpf_pkg::pixel_t rd_center
);

	ctpf_pkg::pixel_t above_mem [MAX_WIDTH];
	ctpf_pkg::pixel_t center_mem [MAX_WIDTH];

	// A row shift writes the old center pixel upward and the new pixel in.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			above_mem[wr_addr] <= wr_above;
			center_mem[wr_addr] <= wr_center;
		end
	end

	// Registered read of both rows at one column.
	always_ff @(posedge clk) begin
		rd_above <= above_mem[rd_addr];
		rd_center <= center_mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== design/ctpf_gamma_rom.sv =====
`default_nettype none

module ctpf_gamma_rom #(
	parameter int LUT_BITS = 12,
	parameter int GAMMA_X1000 = 1120
) (
	input wire logic clk,
	input wire logic [LUT_BITS-1:0] addr,
	output logic [7:0] data
);

	localparam int LUT_SIZE = 1 << LUT_BITS;

	// Entry i counts the output codes whose decision level lies at or below i.
	function automatic logic [8*LUT_SIZE-1:0] build_rom();
		logic [8*LUT_SIZE-1:0] rom;
		longint thr [256];
		longint lmax;
		longint l510;
		longint lx;
		int k;
		int i;
		int c;
		rom = '0;
		lmax = ctpf_pkg::log2_fixed(64'(LUT_SIZE - 1));
		l510 = ctpf_pkg::log2_fixed(64'd510);
		thr[0] = 0;
		for (k = 1; k < 256; k++) begin
			thr[k] = longint'(GAMMA_X1000) * (ctpf_pkg::log2_fixed(64'(2 * k - 1)) - l510);
		end
		c = 0;
		for (i = 1; i < LUT_SIZE; i++) begin
			lx = 1000 * (ctpf_pkg::log2_fixed(64'(i)) - lmax);
			while (c < 255 && thr[c + 1] <= lx) begin
				c++;
			end
			rom[8*i +: 8] = 8'(c);
		end
		return rom;
	endfunction

	localparam logic [8*LUT_SIZE-1:0] ROM_BITS = build_rom();

	always_ff @(posedge clk) begin
		data <= ROM_BITS[{addr, 3'b000} +: 8];
	end

endmodule

`default_nettype wire

// ===== design/ctpf_shade_unit.sv =====
`default_nettype none

module ctpf_shade_unit #(
	parameter int LUT_BITS = 12,
	parameter int GAMMA_X1000 = 1120
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ctpf_pkg::shade_cfg_t cfg,
	input wire ctpf_pkg::shade_ctl_t ctl,
	input wire ctpf_pkg::shade_pix_t pix,
	input wire logic take,
	output logic done,
	output logic [7:0] res_red,
	output logic [7:0] res_green,
	output logic [7:0] res_blue
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LUMA,
		ST_MEAN_ADD,
		ST_MEAN_DIV,
		ST_MEAN_FIX,
		ST_GAIN_MUL,
		ST_GAIN_FIX,
		ST_CHAN,
		ST_DONE
	} state_t;

	// Steps of one neighbour's bloom term.
	localparam logic [2:0] LS_R = 3'd0;
	localparam logic [2:0] LS_G = 3'd1;
	localparam logic [2:0] LS_B = 3'd2;
	localparam logic [2:0] LS_SUM = 3'd3;
	localparam logic [2:0] LS_NORM = 3'd4;

	// Steps of one output channel.
	localparam logic [2:0] CS_ADD = 3'd0;
	localparam logic [2:0] CS_SCAN = 3'd1;
	localparam logic [2:0] CS_SCAN_FIX = 3'd2;
	localparam logic [2:0] CS_MASK = 3'd3;
	localparam logic [2:0] CS_MASK_FIX = 3'd4;
	localparam logic [2:0] CS_ADDR = 3'd5;
	localparam logic [2:0] CS_READ = 3'd6;

	localparam logic [1:0] NB_LAST = 2'd3;
	localparam logic [1:0] CH_LAST = 2'd2;
	localparam int IDX_W = 17 + LUT_BITS;

	state_t state_q;
	logic [2:0] sub_q;
	logic [1:0] nb_q;
	logic [1:0] ch_q;
	ctpf_pkg::shade_ctl_t ctl_q;
	ctpf_pkg::shade_pix_t pix_q;
	logic [28:0] acc_q;
	logic [16:0] luma_q;
	logic pend_q;
	logic [30:0] sum_q;
	logic [2:0] n_q;
	logic [28:0] mean_q;
	logic [28:0] bloom_q;
	logic [29:0] v_q;
	logic [63:0] prod_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;

	ctpf_pkg::pixel_t nb_pix;
	logic nb_ok;
	logic [7:0] nb_byte;
	logic [7:0] ch_byte;
	logic [15:0] thr16;
	logic luma_gt;
	logic [16:0] luma_diff;
	logic [51:0] rnd_sum;
	logic [39:0] prod_rnd;
	logic [31:0] sum_p1;
	logic [31:0] sum_p2;
	logic [12:0] scan_f;
	logic [12:0] mask_f;
	logic [IDX_W-1:0] idx_w;
	logic [LUT_BITS-1:0] rom_addr;
	logic [7:0] rom_data;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [29:0] luma_sum;

	// Neighbour under work: left, right, above, below.
	always_comb begin
		case (nb_q)
			2'd0: begin
				nb_pix = pix_q.left;
				nb_ok = ctl_q.left_ok;
			end
			2'd1: begin
				nb_pix = pix_q.right;
				nb_ok = ctl_q.right_ok;
			end
			2'd2: begin
				nb_pix = pix_q.above;
				nb_ok = ctl_q.above_ok;
			end
			default: begin
				nb_pix = pix_q.below;
				nb_ok = ctl_q.below_ok;
			end
		endcase
	end

	// Channel byte of the neighbour for the current luma step.
	always_comb begin
		case (sub_q)
			LS_R: nb_byte = nb_pix[23:16];
			LS_G: nb_byte = nb_pix[15:8];
			default: nb_byte = nb_pix[7:0];
		endcase
	end

	// Channel byte of the center pixel for the current output channel.
	always_comb begin
		case (ch_q)
			2'd0: ch_byte = pix_q.center[23:16];
			2'd1: ch_byte = pix_q.center[15:8];
			default: ch_byte = pix_q.center[7:0];
		endcase
	end

	assign thr16 = {cfg.bthr, 4'b0000};
	assign luma_gt = luma_q > {1'b0, thr16};
	assign luma_diff = luma_q - {1'b0, thr16};
	assign luma_sum = {1'b0, acc_q} + {1'b0, prod_q[28:0]};

	// Q0.12 rounding of the last product.
	assign rnd_sum = prod_q[51:0] + 52'(ctpf_pkg::HALF_Q12);
	assign prod_rnd = rnd_sum[51:12];

	assign sum_p1 = {1'b0, sum_q} + 32'd1;
	assign sum_p2 = {1'b0, sum_q} + 32'd2;

	assign scan_f = ctl_q.odd_row ? (ctpf_pkg::ONE_Q12 - {1'b0, cfg.scan}) : ctpf_pkg::ONE_Q12;
	assign mask_f = (ch_q != ctl_q.phase) ? (ctpf_pkg::ONE_Q12 - {1'b0, cfg.mask})
		: ctpf_pkg::ONE_Q12;

	// Gamma index: round(v * (2^LUT_BITS - 1) / 65536) on the clamped value.
	assign idx_w = (IDX_W'(v_q[16:0]) << LUT_BITS) - IDX_W'(v_q[16:0]) + IDX_W'(32768);
	assign rom_addr = idx_w[IDX_W-2:16];

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LUMA: begin
				case (sub_q)
					LS_R: begin
						mul_a = 32'(ctpf_pkg::light16(nb_byte));
						mul_b = 32'(ctpf_pkg::LUMA_R);
					end
					LS_G: begin
						mul_a = 32'(ctpf_pkg::light16(nb_byte));
						mul_b = 32'(ctpf_pkg::LUMA_G);
					end
					LS_B: begin
						mul_a = 32'(ctpf_pkg::light16(nb_byte));
						mul_b = 32'(ctpf_pkg::LUMA_B);
					end
					LS_NORM: begin
						mul_a = luma_gt ? 32'(luma_diff) : 32'd0;
						mul_b = 32'(cfg.bnorm);
					end
					default: ;
				endcase
			end
			ST_MEAN_DIV: begin
				mul_a = sum_p1;
				mul_b = ctpf_pkg::RECIP3;
			end
			ST_GAIN_MUL: begin
				mul_a = 32'(mean_q);
				mul_b = 32'(cfg.bstr);
			end
			ST_CHAN: begin
				case (sub_q)
					CS_SCAN: begin
						mul_a = 32'(v_q);
						mul_b = 32'(scan_f);
					end
					CS_MASK: begin
						mul_a = 32'(v_q);
						mul_b = 32'(mask_f);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Product register after the multiplier.
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	ctpf_gamma_rom #(
		.LUT_BITS(LUT_BITS),
		.GAMMA_X1000(GAMMA_X1000)
	) u_gamma_rom (
		.clk(clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	// Sequencer: four bloom terms, their mean and gain, then three channels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sub_q <= '0;
			nb_q <= '0;
			ch_q <= '0;
			ctl_q <= '0;
			pix_q <= '0;
			acc_q <= '0;
			luma_q <= '0;
			pend_q <= 1'b0;
			sum_q <= '0;
			n_q <= '0;
			mean_q <= '0;
			bloom_q <= '0;
			v_q <= '0;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						ctl_q <= ctl;
						pix_q <= pix;
						nb_q <= '0;
						sub_q <= LS_R;
						sum_q <= '0;
						n_q <= '0;
						pend_q <= 1'b0;
						state_q <= ST_LUMA;
					end
				end
				ST_LUMA: begin
					case (sub_q)
						LS_R: begin
							// The previous neighbour's term lands here.
							if (pend_q) begin
								sum_q <= sum_q + 31'(prod_rnd[28:0]);
								n_q <= n_q + 3'd1;
							end
							pend_q <= 1'b0;
							sub_q <= LS_G;
						end
						LS_G: begin
							acc_q <= 29'(ctpf_pkg::HALF_Q12) + prod_q[28:0];
							sub_q <= LS_B;
						end
						LS_B: begin
							acc_q <= acc_q + prod_q[28:0];
							sub_q <= LS_SUM;
						end
						LS_SUM: begin
							luma_q <= luma_sum[28:12];
							sub_q <= LS_NORM;
						end
						default: begin
							// Dark neighbours still count, with a zero term.
							pend_q <= nb_ok;
							sub_q <= LS_R;
							if (nb_q == NB_LAST) begin
								state_q <= ST_MEAN_ADD;
							end else begin
								nb_q <= nb_q + 2'd1;
							end
						end
					endcase
				end
				ST_MEAN_ADD: begin
					if (pend_q) begin
						sum_q <= sum_q + 31'(prod_rnd[28:0]);
						n_q <= n_q + 3'd1;
					end
					pend_q <= 1'b0;
					state_q <= ST_MEAN_DIV;
				end
				ST_MEAN_DIV: begin
					// Rounded mean; a count of three goes through the reciprocal.
					case (n_q)
						3'd0: begin
							mean_q <= '0;
							state_q <= ST_GAIN_MUL;
						end
						3'd1: begin
							mean_q <= sum_q[28:0];
							state_q <= ST_GAIN_MUL;
						end
						3'd2: begin
							mean_q <= sum_p1[29:1];
							state_q <= ST_GAIN_MUL;
						end
						3'd3: begin
							state_q <= ST_MEAN_FIX;
						end
						default: begin
							mean_q <= sum_p2[30:2];
							state_q <= ST_GAIN_MUL;
						end
					endcase
				end
				ST_MEAN_FIX: begin
					mean_q <= prod_q[61:33];
					state_q <= ST_GAIN_MUL;
				end
				ST_GAIN_MUL: begin
					state_q <= ST_GAIN_FIX;
				end
				ST_GAIN_FIX: begin
					bloom_q <= prod_rnd[28:0];
					ch_q <= '0;
					sub_q <= CS_ADD;
					state_q <= ST_CHAN;
				end
				ST_CHAN: begin
					case (sub_q)
						CS_ADD: begin
							v_q <= 30'(ctpf_pkg::light16(ch_byte)) + 30'(bloom_q);
							sub_q <= CS_SCAN;
						end
						CS_SCAN: begin
							sub_q <= CS_SCAN_FIX;
						end
						CS_SCAN_FIX: begin
							v_q <= prod_rnd[29:0];
							sub_q <= CS_MASK;
						end
						CS_MASK: begin
							sub_q <= CS_MASK_FIX;
						end
						CS_MASK_FIX: begin
							// Clamp to full-scale light.
							if (prod_rnd > 40'(ctpf_pkg::LIGHT_MAX)) begin
								v_q <= 30'(ctpf_pkg::LIGHT_MAX);
							end else begin
								v_q <= prod_rnd[29:0];
							end
							sub_q <= CS_ADDR;
						end
						CS_ADDR: begin
							sub_q <= CS_READ;
						end
						default: begin
							case (ch_q)
								2'd0: red_q <= rom_data;
								2'd1: green_q <= rom_data;
								default: blue_q <= rom_data;
							endcase
							sub_q <= CS_ADD;
							if (ch_q == CH_LAST) begin
								state_q <= ST_DONE;
							end else begin
								ch_q <= ch_q + 2'd1;
							end
						end
					endcase
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == ST_DONE);
	assign res_red = red_q;
	assign res_green = green_q;
	assign res_blue = blue_q;

endmodule

`default_nettype wire

// ===== design/crt_tube_pixel_filter_unit.sv =====
`default_nettype none

// CRT tube pixel filter: scanlines, RGB triad mask and neighbour bloom.
// Input channel: in_valid/in_stall with mode, in_red, in_green, in_blue. Pixels
// come in raster order; mode high marks a flush item that drains the last row.
// Output channel: out_valid/out_stall with out_red, out_green, out_blue and
// frame_end, which is high on the last pixel of the frame.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write registers only while the block is idle.
// Output lags input by one row: a pixel is emitted when the pixel below it
// arrives, and flush items emit the last row.
// One item at a time: an item holds in_stall high until its work is done, and
// an item that emits a result also holds it while the previous result still
// waits in the output register. The work runs in turn on the single shared
// 32x32 multiplier, which does every luma, bloom, scanline and mask product.
// Pixels of the first row emit nothing; dropped items are taken without
// holding in_stall.
// A finished result waits in the output register while out_stall is high, and
// the next item is already taken in meanwhile.
// Reset loads the register defaults and restarts at the top-left pixel; the
// line stores hold no defined data until rows have been written.

module crt_tube_pixel_filter_unit #(
	parameter int MAX_WIDTH = 1024,
	parameter int GAMMA_X1000 = 1120,
	parameter int LUT_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic mode,
	input wire logic [7:0] in_red,
	input wire logic [7:0] in_green,
	input wire logic [7:0] in_blue,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic frame_end,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [24:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
	localparam logic [AW-1:0] COL_LAST = AW'(MAX_WIDTH - 1);

	typedef enum logic [2:0] {
		T_IDLE,
		T_READ,
		T_FETCH,
		T_LAUNCH,
		T_WAIT
	} state_t;

	state_t state_q;
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic [11:0] scan_q;
	logic [11:0] mask_q;
	logic [11:0] bstr_q;
	logic [11:0] bthr_q;
	logic [24:0] bnorm_q;
	logic [AW-1:0] col_q;
	logic [1:0] phase_q;
	logic [10:0] row_q;
	ctpf_pkg::pixel_t left_q;
	ctpf_pkg::pixel_t cur_q;
	ctpf_pkg::pixel_t center_q;
	ctpf_pkg::pixel_t above_q;
	logic mode_q;
	logic last_q;
	logic emit_q;
	logic left_ok_q;
	logic above_ok_q;
	logic odd_q;
	logic fe_q;
	logic out_valid_q;
	logic [7:0] out_red_q;
	logic [7:0] out_green_q;
	logic [7:0] out_blue_q;
	logic out_fe_q;

	logic [12:0] eff_w;
	logic [10:0] eff_h;
	logic drain;
	logic last_col;
	logic in_take;
	logic act;
	logic [AW-1:0] col_next;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	ctpf_pkg::pixel_t rd_above;
	ctpf_pkg::pixel_t rd_center;
	ctpf_pkg::shade_cfg_t shade_cfg;
	ctpf_pkg::shade_ctl_t shade_ctl;
	ctpf_pkg::shade_pix_t shade_pix;
	logic shade_done;
	logic [7:0] res_red;
	logic [7:0] res_green;
	logic [7:0] res_blue;
	logic out_free;
	logic take;

	// Effective geometry: zero acts as one, width saturates at the store depth.
	assign eff_w = (width_q == 11'd0) ? 13'd1
		: ((13'(width_q) > MAXW) ? MAXW : 13'(width_q));
	assign eff_h = (height_q == 11'd0) ? 11'd1 : height_q;
	assign drain = (row_q >= eff_h);
	assign last_col = (13'(col_q) + 13'd1) >= eff_w;

	assign in_stall = (state_q != T_IDLE);
	assign in_take = in_valid && !in_stall;
	assign act = (mode == ctpf_pkg::MODE_PIXEL) ? !drain : drain;

	assign col_next = (col_q == COL_LAST) ? '0 : col_q + AW'(1);
	assign rd_addr = (state_q == T_FETCH) ? col_next : col_q;
	assign wr_en = (state_q == T_FETCH) && (mode_q == ctpf_pkg::MODE_PIXEL);

	assign out_free = !out_valid_q || !out_stall;
	assign take = (state_q == T_WAIT) && shade_done && out_free;

	assign cfg_ready = 1'b1;

	ctpf_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk(clk),
		.rd_addr(rd_addr),
		.wr_en(wr_en),
		.wr_addr(col_q),
		.wr_above(rd_center),
		.wr_center(cur_q),
		.rd_above(rd_above),
		.rd_center(rd_center)
	);

	assign shade_cfg.scan = scan_q;
	assign shade_cfg.mask = mask_q;
	assign shade_cfg.bstr = bstr_q;
	assign shade_cfg.bthr = bthr_q;
	assign shade_cfg.bnorm = bnorm_q;

	assign shade_ctl.start = (state_q == T_LAUNCH) && emit_q;
	assign shade_ctl.left_ok = left_ok_q;
	assign shade_ctl.right_ok = !last_q;
	assign shade_ctl.above_ok = above_ok_q;
	assign shade_ctl.below_ok = (mode_q == ctpf_pkg::MODE_PIXEL);
	assign shade_ctl.odd_row = odd_q;
	assign shade_ctl.phase = phase_q;

	assign shade_pix.center = center_q;
	assign shade_pix.left = left_q;
	assign shade_pix.right = rd_center;
	assign shade_pix.above = above_q;
	assign shade_pix.below = cur_q;

	ctpf_shade_unit #(
		.LUT_BITS(LUT_BITS),
		.GAMMA_X1000(GAMMA_X1000)
	) u_shade_unit (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(shade_cfg),
		.ctl(shade_ctl),
		.pix(shade_pix),
		.take(take),
		.done(shade_done),
		.res_red(res_red),
		.res_green(res_green),
		.res_blue(res_blue)
	);

	// Item control, raster counters, configuration and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			width_q <= 11'd256;
			height_q <= 11'd240;
			scan_q <= 12'd983;
			mask_q <= 12'd410;
			bstr_q <= 12'd328;
			bthr_q <= 12'd2867;
			bnorm_q <= 25'd13653;
			col_q <= '0;
			phase_q <= '0;
			row_q <= '0;
			left_q <= '0;
			cur_q <= '0;
			center_q <= '0;
			above_q <= '0;
			mode_q <= ctpf_pkg::MODE_PIXEL;
			last_q <= 1'b0;
			emit_q <= 1'b0;
			left_ok_q <= 1'b0;
			above_ok_q <= 1'b0;
			odd_q <= 1'b0;
			fe_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_red_q <= '0;
			out_green_q <= '0;
			out_blue_q <= '0;
			out_fe_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ctpf_pkg::CFG_WIDTH: width_q <= cfg_data[10:0];
					ctpf_pkg::CFG_HEIGHT: height_q <= cfg_data[10:0];
					ctpf_pkg::CFG_SCAN: scan_q <= cfg_data[11:0];
					ctpf_pkg::CFG_MASK: mask_q <= cfg_data[11:0];
					ctpf_pkg::CFG_BSTR: bstr_q <= cfg_data[11:0];
					ctpf_pkg::CFG_BTHR: bthr_q <= cfg_data[11:0];
					ctpf_pkg::CFG_BNORM: bnorm_q <= cfg_data;
					default: ;
				endcase
			end

			// A taken result empties the register unless a new one loads now.
			if (out_valid_q && !out_stall && !take) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				T_IDLE: begin
					// Items that do not fit the current phase are dropped.
					if (in_take && act) begin
						mode_q <= mode;
						cur_q <= {in_red, in_green, in_blue};
						last_q <= last_col;
						emit_q <= (mode == ctpf_pkg::MODE_FLUSH) || (row_q != 11'd0);
						left_ok_q <= (col_q != '0);
						above_ok_q <= (row_q > 11'd1);
						odd_q <= !row_q[0];
						state_q <= T_READ;
					end
				end
				T_READ: begin
					state_q <= T_FETCH;
				end
				T_FETCH: begin
					center_q <= rd_center;
					above_q <= rd_above;
					state_q <= T_LAUNCH;
				end
				T_LAUNCH: begin
					left_q <= center_q;
					fe_q <= (mode_q == ctpf_pkg::MODE_FLUSH) && last_q;
					if (last_q) begin
						col_q <= '0;
						phase_q <= '0;
						if (mode_q == ctpf_pkg::MODE_PIXEL) begin
							row_q <= row_q + 11'd1;
						end else begin
							row_q <= '0;
						end
					end else begin
						col_q <= col_q + AW'(1);
						phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
					end
					state_q <= emit_q ? T_WAIT : T_IDLE;
				end
				T_WAIT: begin
					if (take) begin
						out_valid_q <= 1'b1;
						out_red_q <= res_red;
						out_green_q <= res_green;
						out_blue_q <= res_blue;
						out_fe_q <= fe_q;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_red = out_red_q;
	assign out_green = out_green_q;
	assign out_blue = out_blue_q;
	assign frame_end = out_fe_q;

endmodule

`default_nettype wire

// ===== design/ctpf_checker.sv =====
`default_nettype none

module ctpf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic mode,
	input wire logic [7:0] in_red,
	input wire logic [7:0] in_green,
	input wire logic [7:0] in_blue,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] out_red,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_blue,
	input wire logic frame_end,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [24:0] cfg_data
);

	// A waiting result is not withdrawn.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A waiting result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({out_red, out_green, out_blue, frame_end}))
		else $error("stalled result changed");

	// A new result only appears at the end of an item's work.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without item in progress");

	// The block is busy for several cycles before each result.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall, 4))
		else $error("result appeared too early");

endmodule

bind crt_tube_pixel_filter_unit ctpf_checker u_checker (.*);

`default_nettype wire
